>>> hw/rtl/lisp_header_version_check_defines.svh
// ----------------------------------------------------------------------------
// lisp_header_version_check_defines.svh
// Assertion macros shared by the header version check block.
// ----------------------------------------------------------------------------
`ifndef LISP_HEADER_VERSION_CHECK_DEFINES_SVH
`define LISP_HEADER_VERSION_CHECK_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define LHVC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define LHVC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lhvc_pkg.sv
// ----------------------------------------------------------------------------
// lhvc_pkg
// Types, codes and helpers for the LISP header map-version check.
// ----------------------------------------------------------------------------
package lhvc_pkg;

    localparam int VERSION_BITS = 12;
    localparam int COUNT_BITS   = 32;
    localparam int TOTAL_BITS   = 32;
    localparam int NONCE_BITS   = 24;
    localparam int LSB_BITS     = 32;
    localparam int FLAG_BITS    = 3;

    // Header flag positions.
    localparam int FLAG_N = 0;
    localparam int FLAG_V = 1;
    localparam int FLAG_L = 2;

    // Remote cache modes; mode three behaves as a versioned entry.
    localparam logic [1:0] RMODE_NONE = 2'd0;
    localparam int RMODE_VERSIONED_BIT = 1;

    // Notice codes.
    localparam logic [1:0] NOTICE_NONE           = 2'd0;
    localparam logic [1:0] NOTICE_REMOTE_STALE   = 2'd1;
    localparam logic [1:0] NOTICE_LOCAL_STALE    = 2'd2;
    localparam logic [1:0] NOTICE_STATUS_CHANGED = 2'd3;

    // Serial arithmetic window: WRAP is half the version space minus one.
    localparam logic [VERSION_BITS-1:0] VERSION_WRAP =
        VERSION_BITS'((1 << (VERSION_BITS - 1)) - 1);
    localparam logic [VERSION_BITS-1:0] VERSION_HALF =
        VERSION_BITS'(1 << (VERSION_BITS - 1));

    typedef struct packed {
        logic [FLAG_BITS-1:0]    header_flags;
        logic [NONCE_BITS-1:0]   nonce;
        logic [VERSION_BITS-1:0] dest_version;
        logic [VERSION_BITS-1:0] src_version;
        logic [LSB_BITS-1:0]     status_bits;
        logic                    local_versioned;
        logic [VERSION_BITS-1:0] local_version;
        logic [1:0]              remote_mode;
        logic [VERSION_BITS-1:0] remote_version;
        logic [LSB_BITS-1:0]     remote_status_bits;
        logic                    is_ipv6;
    } hdr_t;

    typedef struct packed {
        logic                  accept;
        logic [1:0]            notice;
        logic                  record_nonce;
        logic [NONCE_BITS-1:0] recorded_nonce;
        logic [TOTAL_BITS-1:0] bad_dest_total;
        logic [TOTAL_BITS-1:0] bad_src_total;
    } res_t;

    // Counter update request from the decision logic.
    typedef struct packed {
        logic family;
        logic dest;
        logic src;
    } bump_t;

    typedef struct packed {
        logic       accept;
        logic [1:0] notice;
        logic       record_nonce;
        bump_t      bump;
    } verdict_t;

    // True when version a is newer than version b under wrap-around ordering.
    function automatic logic newer_than(input logic [VERSION_BITS-1:0] a,
                                        input logic [VERSION_BITS-1:0] b);
        logic [VERSION_BITS-1:0] d_ab;
        logic [VERSION_BITS-1:0] d_ba;
        d_ab = a - b;
        d_ba = b - a;
        return ((a > b) && (d_ab < VERSION_WRAP)) || ((b > a) && (d_ba > VERSION_HALF));
    endfunction

endpackage

>>> hw/rtl/lhvc_decide.sv
// ----------------------------------------------------------------------------
// lhvc_decide
// Classifies one registered header: acceptance, notice, nonce and counters.
// ----------------------------------------------------------------------------
module lhvc_decide
(
    input  lhvc_pkg::hdr_t     hdr,
    output lhvc_pkg::verdict_t verdict
);

    logic remote;
    logic remote_versioned;

    assign remote           = (hdr.remote_mode != lhvc_pkg::RMODE_NONE);
    assign remote_versioned = hdr.remote_mode[lhvc_pkg::RMODE_VERSIONED_BIT];

    always_comb
    begin
        verdict             = '0;
        verdict.accept      = 1'b1;
        verdict.notice      = lhvc_pkg::NOTICE_NONE;
        verdict.bump.family = hdr.is_ipv6;

        // The N bit takes precedence; versions are then ignored.
        if (hdr.header_flags[lhvc_pkg::FLAG_N])
        begin
            verdict.record_nonce = remote;
        end
        else if (hdr.header_flags[lhvc_pkg::FLAG_V])
        begin
            if (hdr.local_versioned && (hdr.dest_version != hdr.local_version))
            begin
                if (lhvc_pkg::newer_than(hdr.dest_version, hdr.local_version))
                begin
                    verdict.bump.dest = 1'b1;
                    verdict.accept    = 1'b0;
                end
                else
                begin
                    verdict.notice = lhvc_pkg::NOTICE_REMOTE_STALE;
                end
            end
            else if (remote && remote_versioned && (hdr.src_version != hdr.remote_version))
            begin
                if (lhvc_pkg::newer_than(hdr.src_version, hdr.remote_version))
                begin
                    verdict.notice = lhvc_pkg::NOTICE_LOCAL_STALE;
                end
                else
                begin
                    verdict.bump.src = 1'b1;
                    verdict.accept   = 1'b0;
                end
            end
        end

        // Locator status bits are only checked when no version notice was raised.
        if ((verdict.notice == lhvc_pkg::NOTICE_NONE) && hdr.header_flags[lhvc_pkg::FLAG_L]
            && remote && (hdr.status_bits != hdr.remote_status_bits))
        begin
            verdict.notice = lhvc_pkg::NOTICE_STATUS_CHANGED;
        end
    end

endmodule

>>> hw/rtl/lhvc_counters.sv
// ----------------------------------------------------------------------------
// lhvc_counters
// Per-family saturating counters of rejected destination and source versions.
// ----------------------------------------------------------------------------
module lhvc_counters
#(
    parameter int COUNT_BITS = lhvc_pkg::COUNT_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            update,
    input  lhvc_pkg::bump_t                 bump,
    output logic [lhvc_pkg::TOTAL_BITS-1:0] dest_total,
    output logic [lhvc_pkg::TOTAL_BITS-1:0] src_total
);

    localparam int EXT_BITS = (COUNT_BITS > lhvc_pkg::TOTAL_BITS) ?
                              COUNT_BITS : lhvc_pkg::TOTAL_BITS;

    logic [COUNT_BITS-1:0] dest_cnt_reg [2];
    logic [COUNT_BITS-1:0] src_cnt_reg  [2];
    logic [COUNT_BITS-1:0] dest_cnt_next;
    logic [COUNT_BITS-1:0] src_cnt_next;
    logic [COUNT_BITS-1:0] dest_cur;
    logic [COUNT_BITS-1:0] src_cur;
    logic [EXT_BITS-1:0]   dest_ext;
    logic [EXT_BITS-1:0]   src_ext;

    assign dest_cur = dest_cnt_reg[bump.family];
    assign src_cur  = src_cnt_reg[bump.family];

    // A full counter holds its maximum value.
    assign dest_cnt_next = (bump.dest && (dest_cur != '1)) ?
                           dest_cur + COUNT_BITS'(1) : dest_cur;
    assign src_cnt_next  = (bump.src && (src_cur != '1)) ?
                           src_cur + COUNT_BITS'(1) : src_cur;

    assign dest_ext   = EXT_BITS'(dest_cnt_next);
    assign src_ext    = EXT_BITS'(src_cnt_next);
    assign dest_total = dest_ext[lhvc_pkg::TOTAL_BITS-1:0];
    assign src_total  = src_ext[lhvc_pkg::TOTAL_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_cnt_reg[0] <= '0;
            dest_cnt_reg[1] <= '0;
            src_cnt_reg[0]  <= '0;
            src_cnt_reg[1]  <= '0;
        end
        else if (update)
        begin
            dest_cnt_reg[bump.family] <= dest_cnt_next;
            src_cnt_reg[bump.family]  <= src_cnt_next;
        end
    end

endmodule

>>> hw/rtl/lisp_header_version_check.sv
// ----------------------------------------------------------------------------
// lisp_header_version_check
// Map-version and locator-status check of received LISP data headers.
//
// Each header item on the hdr channel, together with the local and cached
// remote mapping data, yields exactly one result item on the res channel.
// The block is a two-register pipeline: an input register holds the header,
// short compare logic classifies it, and the result register holds the
// verdict along with the updated per-family reject counters. Sustained rate
// is one item per clock cycle while res_stall stays low. An accepted header
// moves from the input register into the result register, where it is held
// until res_stall is low. The result register frees the input side, so a new
// header is taken while a finished result waits; hdr_stall only rises when
// both registers are full and res_stall is high. The counters for IPv4 and
// IPv6 are cleared by reset, saturate at their maximum and are reported as
// the low 32 bits of the value after this item's update.
// ----------------------------------------------------------------------------
`include "lisp_header_version_check_defines.svh"

module lisp_header_version_check
#(
    parameter int COUNT_BITS = lhvc_pkg::COUNT_BITS
)
(
    input  logic           clk,
    input  logic           rst_n,

    input  logic           hdr_valid,
    output logic           hdr_stall,
    input  lhvc_pkg::hdr_t hdr,

    output logic           res_valid,
    input  logic           res_stall,
    output lhvc_pkg::res_t res
);

    // Input register stage.
    logic               s1_valid_reg;
    logic               s1_valid_next;
    lhvc_pkg::hdr_t     s1_hdr_reg;

    // Result register stage.
    logic               res_valid_reg;
    logic               res_valid_next;
    lhvc_pkg::res_t     res_reg;
    lhvc_pkg::res_t     res_next;

    lhvc_pkg::verdict_t verdict;
    logic               res_advance;
    logic               s1_advance;
    logic               hdr_take;
    logic [lhvc_pkg::TOTAL_BITS-1:0] dest_total;
    logic [lhvc_pkg::TOTAL_BITS-1:0] src_total;

    // Terms used by the checks at the end of the module.
    logic               res_rejected;
    logic               res_stale;
    logic               res_recording;
    logic               res_no_record;
    logic               res_nonce_clear;
    logic               pipe_full;

    // The result register can load whenever it is empty or being drained.
    assign res_advance = !res_valid_reg || !res_stall;
    assign s1_advance  = s1_valid_reg && res_advance;
    assign hdr_stall   = s1_valid_reg && !res_advance;
    assign hdr_take    = hdr_valid && !hdr_stall;

    assign s1_valid_next  = hdr_stall ? s1_valid_reg : hdr_valid;
    assign res_valid_next = res_advance ? s1_valid_reg : res_valid_reg;

    lhvc_decide u_decide
    (
        .hdr     (s1_hdr_reg),
        .verdict (verdict)
    );

    // Counters commit exactly when the item moves into the result register,
    // so the totals it carries include its own update.
    lhvc_counters
    #(
        .COUNT_BITS (COUNT_BITS)
    )
    u_counters
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (s1_advance),
        .bump       (verdict.bump),
        .dest_total (dest_total),
        .src_total  (src_total)
    );

    always_comb
    begin
        res_next.accept         = verdict.accept;
        res_next.notice         = verdict.notice;
        res_next.record_nonce   = verdict.record_nonce;
        res_next.recorded_nonce = verdict.record_nonce ? s1_hdr_reg.nonce : '0;
        res_next.bad_dest_total = dest_total;
        res_next.bad_src_total  = src_total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_take)
        begin
            s1_hdr_reg <= hdr;
        end
        if (s1_advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign res_rejected    = res_valid_reg && !res_reg.accept;
    assign res_stale       = (res_reg.notice == lhvc_pkg::NOTICE_REMOTE_STALE)
                             || (res_reg.notice == lhvc_pkg::NOTICE_LOCAL_STALE);
    assign res_recording   = res_valid_reg && res_reg.record_nonce;
    assign res_no_record   = res_valid_reg && !res_reg.record_nonce;
    assign res_nonce_clear = (res_reg.recorded_nonce == '0);
    assign pipe_full       = s1_valid_reg && res_valid_reg && res_stall;

    // A rejected header never carries a version staleness notice.
    `LHVC_ASSERT_IMPLIES(a_reject_no_stale, res_rejected, !res_stale, "stale notice on reject")
    // Nonce recording only happens on the nonce path, which never rejects.
    `LHVC_ASSERT_IMPLIES(a_record_accepts, res_recording, res_reg.accept, "nonce on reject")
    // The nonce value is zero whenever it is not to be recorded.
    `LHVC_ASSERT_IMPLIES(a_nonce_zero, res_no_record, res_nonce_clear, "stray nonce value")
    // The input side only stalls when both stages are full and the output stalls.
    `LHVC_ASSERT_ALWAYS(a_stall_only_full, !hdr_stall || pipe_full, "input stalled with room")

endmodule
